@@ src/chained_hash_table_with_overflow_stats_core_defines.svh @@
// assertion macros for the chained hash table core
// used by the top level only; expects aclk and aresetn in scope
`ifndef CHAINED_HASH_TABLE_WITH_OVERFLOW_STATS_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_WITH_OVERFLOW_STATS_CORE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define CHT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define CHT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/cht_pkg.sv @@
// shared types, codes and constants for the chained hash table core
// no dependencies; imported by every module of the block
`default_nettype none

package cht_pkg;

    localparam int NUM_BUCKETS_DEF = 7;
    localparam int POOL_SIZE_DEF   = 64;
    localparam int KEY_BITS        = 16;

    localparam int OP_W      = 2;
    localparam int BKT_IN_W  = 3;
    localparam int STATUS_W  = 2;
    localparam int BKT_OUT_W = 3;
    localparam int KEY_OUT_W = 16;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 6;
    localparam int SCNT_W    = 3;

    // overflow counters saturate at the top of their range
    localparam int              OVF_W   = 7;
    localparam logic [OVF_W-1:0] OVF_MAX = '1;

    // dividend width of the divider, holds a key or the counter sum
    localparam int DIV_W = 16;

    localparam int STAT_TOP = 63;
    localparam int SCNT_TOP = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_STATS  = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] RES_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] RES_POOL_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] RES_BAD_BUCKET = 2'd2;
    localparam logic [STATUS_W-1:0] RES_EMPTY      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KEY_BITS-1:0] key;
        logic [BKT_IN_W-1:0] bucket;
    } cht_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [BKT_OUT_W-1:0] bucket_out;
        logic [KEY_OUT_W-1:0] key_out;
        logic [POS_W-1:0]     position;
        logic [STAT_W-1:0]    stat_min;
        logic [SCNT_W-1:0]    stat_min_count;
        logic [STAT_W-1:0]    stat_max;
        logic [SCNT_W-1:0]    stat_max_count;
        logic [STAT_W-1:0]    stat_avg;
        logic                 last;
    } cht_out_t;

    // control of the statistics accumulator
    typedef struct packed {
        logic valid;
        logic first;
    } stat_ctl_t;

endpackage

`default_nettype wire

@@ src/cht_divider.sv @@
// reciprocal-multiplication divider by the bucket count: quotient and remainder
// depends on cht_pkg; used for the bucket of a key and the counter average
`default_nettype none

module cht_divider
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [DIV_W-1:0]               dividend,
    output logic                                done,
    output logic [DIV_W-1:0]                    quotient,
    output logic [$clog2(NUM_BUCKETS)-1:0]      remainder
);

    localparam int RW     = $clog2(NUM_BUCKETS);
    // q = (n * ceil(2^SH / M)) >> SH is exact for every DIV_W-bit n
    localparam int SH     = DIV_W + RW;
    localparam int REC_W  = DIV_W + 1;
    localparam int PROD_W = DIV_W + REC_W;

    localparam longint unsigned REC_FULL =
        ((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
    localparam logic [REC_W-1:0] RECIP   = REC_W'(REC_FULL);
    localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(NUM_BUCKETS);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  num_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [RW-1:0]     rem_reg;

    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  back;
    logic [DIV_W-1:0]  diff;

    // the quotient is registered from the reciprocal product, then the remainder from it
    assign prod = PROD_W'(dividend) * PROD_W'(RECIP);
    assign back = quo_reg * DIVISOR;
    assign diff = num_reg - back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            quo_reg <= DIV_W'(prod >> SH);
        end
        if (busy_reg) begin
            rem_reg <= diff[RW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ src/cht_stats.sv @@
// running minimum, maximum, their multiplicities and the sum of overflow counters
// depends on cht_pkg; fed one counter per cycle by the bucket table walk
`default_nettype none

module cht_stats
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  wire logic                                      aclk,
    input  wire stat_ctl_t                                 ctl,
    input  wire logic [OVF_W-1:0]                          cnt_in,
    output logic [OVF_W-1:0]                               min_val,
    output logic [$clog2(NUM_BUCKETS+1)-1:0]               min_num,
    output logic [OVF_W-1:0]                               max_val,
    output logic [$clog2(NUM_BUCKETS+1)-1:0]               max_num,
    output logic [OVF_W+$clog2(NUM_BUCKETS)-1:0]           sum
);

    localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
    localparam int SUM_W = OVF_W + $clog2(NUM_BUCKETS);

    logic [OVF_W-1:0] min_reg, min_next;
    logic [OVF_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0] min_n_reg, min_n_next;
    logic [CNT_W-1:0] max_n_reg, max_n_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    always_comb begin
        min_next   = min_reg;
        max_next   = max_reg;
        min_n_next = min_n_reg;
        max_n_next = max_n_reg;
        sum_next   = sum_reg;
        if (ctl.valid) begin
            if (ctl.first) begin
                min_next   = cnt_in;
                max_next   = cnt_in;
                min_n_next = CNT_W'(1);
                max_n_next = CNT_W'(1);
                sum_next   = SUM_W'(cnt_in);
            end else begin
                sum_next = sum_reg + SUM_W'(cnt_in);
                if (cnt_in > max_reg) begin
                    max_next   = cnt_in;
                    max_n_next = CNT_W'(1);
                end else if (cnt_in == max_reg) begin
                    max_n_next = max_n_reg + CNT_W'(1);
                end
                if (cnt_in < min_reg) begin
                    min_next   = cnt_in;
                    min_n_next = CNT_W'(1);
                end else if (cnt_in == min_reg) begin
                    min_n_next = min_n_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        min_reg   <= min_next;
        max_reg   <= max_next;
        min_n_reg <= min_n_next;
        max_n_reg <= max_n_next;
        sum_reg   <= sum_next;
    end

    assign min_val = min_reg;
    assign min_num = min_n_reg;
    assign max_val = max_reg;
    assign max_num = max_n_reg;
    assign sum     = sum_reg;

endmodule

`default_nettype wire

@@ src/chained_hash_table_with_overflow_stats_core.sv @@
// Chained hash table with per-bucket overflow counters.
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// insert a key, query the overflow statistics, or list the keys of one bucket.
// Result channel m_valid/m_ready/m_data gives the result transactions; the
// last one caused by an operation has last set. Op code 3 gives no result.
// Operations run one at a time; the steps from acceptance to the result being
// loaded in the output register:
//   insert: key mod NUM_BUCKETS by reciprocal multiplication, then a bucket
//           table read, the node write and, when a chain is extended, a link
//           write; when the pool is full the result follows the division
//   statistics: one bucket table read per cycle, then the divider for the average
//   list: a bucket table read, then one node memory read per key;
//           an empty or invalid bucket needs no memory read
// A finished result sits in the output register, so the next operation is
// accepted while it waits. When the receiver stalls, a list walk pauses and
// any other operation holds its result until the register frees.
// Reset (aresetn low, synchronous) clears occupancy and the node count at once,
// so every counter reads as zero; no clearing pass, ready the cycle after.
// Node keys, links and bucket head/tail pointers are held in memories. A node
// entry is only read once written; an unwritten bucket entry is read but ignored.
`default_nettype none
`include "chained_hash_table_with_overflow_stats_core_defines.svh"

module chained_hash_table_with_overflow_stats_core
    import cht_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int POOL_SIZE   = POOL_SIZE_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire cht_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output cht_out_t     m_data
);

    localparam int RW     = $clog2(NUM_BUCKETS);
    localparam int NODE_W = $clog2(POOL_SIZE);
    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int SUM_W  = OVF_W + $clog2(NUM_BUCKETS);

    localparam logic [NODE_W:0] POOL_LIMIT = (NODE_W+1)'(POOL_SIZE);
    localparam logic [RW-1:0]   LAST_BKT   = RW'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
        logic [OVF_W-1:0]  ovf;
    } bkt_entry_t;

    typedef struct packed {
        logic [NODE_W-1:0]   link;
        logic [KEY_BITS-1:0] key;
    } node_entry_t;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_INS_DIV  = 11'b000_0000_0010,
        S_INS_A    = 11'b000_0000_0100,
        S_INS_B    = 11'b000_0000_1000,
        S_LST_HEAD = 11'b000_0001_0000,
        S_LST_DATA = 11'b000_0010_0000,
        S_ST_RD    = 11'b000_0100_0000,
        S_ST_END   = 11'b000_1000_0000,
        S_ST_DIVGO = 11'b001_0000_0000,
        S_ST_DIV   = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [NUM_BUCKETS-1:0] used_reg, used_next;
    logic [NODE_W:0]      nodes_reg, nodes_next;
    logic                 m_valid_reg;
    cht_out_t             m_data_reg;
    logic                 rd_v_reg, rd_v_next;

    logic [RW-1:0]        b_reg, b_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [NODE_W-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [RW-1:0]        st_idx_reg, st_idx_next;
    logic                 rd_first_reg, rd_first_next;
    logic                 rd_used_reg, rd_used_next;
    cht_out_t             res_reg, res_next;

    // bucket table memory
    bkt_entry_t           bkt_mem [NUM_BUCKETS];
    logic                 bm_re;
    logic [RW-1:0]        bm_raddr;
    bkt_entry_t           bm_rdata_reg;
    logic                 bm_we;
    logic [RW-1:0]        bm_waddr;
    bkt_entry_t           bm_wdata;

    // node pool memory, key and link written under separate enables
    node_entry_t          node_mem [POOL_SIZE];
    logic                 nm_re;
    logic [NODE_W-1:0]    nm_raddr;
    node_entry_t          nm_rdata_reg;
    logic                 nm_key_we;
    logic                 nm_link_we;
    logic [NODE_W-1:0]    nm_waddr;
    node_entry_t          nm_wdata;

    logic                 div_start;
    logic [DIV_W-1:0]     div_din;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [RW-1:0]        div_rem;
    logic                 div_wait;

    stat_ctl_t            st_ctl;
    logic [OVF_W-1:0]     st_cnt;
    logic [OVF_W-1:0]     st_min;
    logic [OVF_W-1:0]     st_max;
    logic [CNT_W-1:0]     st_min_n;
    logic [CNT_W-1:0]     st_max_n;
    logic [SUM_W-1:0]     st_sum;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    cht_out_t             out_data;
    logic                 bkt_ok;
    logic                 ins_used;
    logic [OVF_W-1:0]     ovf_inc;
    logic [OVF_W-1:0]     ovf_new;
    logic [NODE_W-1:0]    new_node;
    logic                 pool_full;
    logic                 lst_last;

    cht_divider #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_din),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    cht_stats #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_stats (
        .aclk    (aclk),
        .ctl     (st_ctl),
        .cnt_in  (st_cnt),
        .min_val (st_min),
        .min_num (st_min_n),
        .max_val (st_max),
        .max_num (st_max_n),
        .sum     (st_sum)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign bkt_ok   = int'(s_data.bucket) < NUM_BUCKETS;
    assign div_wait = (state_reg == S_INS_DIV) || (state_reg == S_ST_DIV);

    assign ins_used  = used_reg[b_reg];
    assign ovf_inc   = (bm_rdata_reg.ovf == OVF_MAX) ? OVF_MAX
                                                     : bm_rdata_reg.ovf + OVF_W'(1);
    // an unoccupied bucket's table entry holds no valid data, its counter reads as zero
    assign ovf_new   = ins_used ? ovf_inc : '0;
    assign new_node  = nodes_reg[NODE_W-1:0];
    assign pool_full = nodes_reg >= POOL_LIMIT;
    assign lst_last  = (node_reg == tail_reg) || (pos_reg == '1);

    assign st_ctl.valid = rd_v_reg;
    assign st_ctl.first = rd_first_reg;
    assign st_cnt       = rd_used_reg ? bm_rdata_reg.ovf : '0;

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        nodes_next    = nodes_reg;
        rd_v_next     = 1'b0;
        b_next        = b_reg;
        key_next      = key_reg;
        tail_next     = tail_reg;
        node_next     = node_reg;
        pos_next      = pos_reg;
        st_idx_next   = st_idx_reg;
        rd_first_next = rd_first_reg;
        rd_used_next  = rd_used_reg;
        res_next      = res_reg;

        bm_re      = 1'b0;
        bm_raddr   = b_reg;
        bm_we      = 1'b0;
        bm_waddr   = b_reg;
        bm_wdata   = '0;
        nm_re      = 1'b0;
        nm_raddr   = node_reg;
        nm_key_we  = 1'b0;
        nm_link_we = 1'b0;
        nm_waddr   = new_node;
        nm_wdata   = '0;
        div_start  = 1'b0;
        div_din    = DIV_W'(s_data.key);
        out_load   = 1'b0;
        out_data   = res_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_data.op)
                        OP_INSERT: begin
                            div_start  = 1'b1;
                            key_next   = s_data.key;
                            state_next = S_INS_DIV;
                        end
                        OP_STATS: begin
                            st_idx_next = '0;
                            state_next  = S_ST_RD;
                        end
                        OP_LIST: begin
                            b_next   = RW'(s_data.bucket);
                            pos_next = '0;
                            res_next = '0;
                            res_next.bucket_out = s_data.bucket;
                            res_next.last       = 1'b1;
                            if (!bkt_ok) begin
                                res_next.status = RES_BAD_BUCKET;
                                state_next      = S_RESP;
                            end else if (!used_reg[RW'(s_data.bucket)]) begin
                                res_next.status = RES_EMPTY;
                                state_next      = S_RESP;
                            end else begin
                                bm_re      = 1'b1;
                                bm_raddr   = RW'(s_data.bucket);
                                state_next = S_LST_HEAD;
                            end
                        end
                        default: begin
                            // op code without meaning: taken and dropped
                        end
                    endcase
                end
            end
            S_INS_DIV: begin
                if (div_done) begin
                    b_next   = div_rem;
                    res_next = '0;
                    res_next.bucket_out = BKT_OUT_W'(div_rem);
                    res_next.last       = 1'b1;
                    if (pool_full) begin
                        res_next.status = RES_POOL_FULL;
                        state_next      = S_RESP;
                    end else begin
                        bm_re      = 1'b1;
                        bm_raddr   = div_rem;
                        state_next = S_INS_A;
                    end
                end
            end
            S_INS_A: begin
                nm_key_we     = 1'b1;
                nm_link_we    = 1'b1;
                nm_waddr      = new_node;
                nm_wdata.key  = key_reg;
                nm_wdata.link = '0;
                bm_we         = 1'b1;
                bm_waddr      = b_reg;
                bm_wdata.head = ins_used ? bm_rdata_reg.head : new_node;
                bm_wdata.tail = new_node;
                bm_wdata.ovf  = ovf_new;
                used_next[b_reg] = 1'b1;
                nodes_next       = nodes_reg + (NODE_W+1)'(1);
                res_next.status   = RES_OK;
                res_next.position = POS_W'(ovf_new);
                if (ins_used) begin
                    tail_next  = bm_rdata_reg.tail;
                    node_next  = new_node;
                    state_next = S_INS_B;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_INS_B: begin
                // hook the new node behind the old tail, its key is left alone
                nm_link_we    = 1'b1;
                nm_waddr      = tail_reg;
                nm_wdata.link = node_reg;
                state_next    = S_RESP;
            end
            S_LST_HEAD: begin
                tail_next  = bm_rdata_reg.tail;
                node_next  = bm_rdata_reg.head;
                nm_re      = 1'b1;
                nm_raddr   = bm_rdata_reg.head;
                state_next = S_LST_DATA;
            end
            S_LST_DATA: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_data            = '0;
                    out_data.status     = RES_OK;
                    out_data.bucket_out = BKT_OUT_W'(b_reg);
                    out_data.key_out    = KEY_OUT_W'(nm_rdata_reg.key);
                    out_data.position   = pos_reg;
                    out_data.last       = lst_last;
                    if (lst_last) begin
                        state_next = S_IDLE;
                    end else begin
                        nm_re     = 1'b1;
                        nm_raddr  = nm_rdata_reg.link;
                        node_next = nm_rdata_reg.link;
                        pos_next  = pos_reg + POS_W'(1);
                    end
                end
            end
            S_ST_RD: begin
                bm_re         = 1'b1;
                bm_raddr      = st_idx_reg;
                rd_v_next     = 1'b1;
                rd_first_next = (st_idx_reg == '0);
                rd_used_next  = used_reg[st_idx_reg];
                if (st_idx_reg == LAST_BKT) begin
                    state_next = S_ST_END;
                end else begin
                    st_idx_next = st_idx_reg + RW'(1);
                end
            end
            S_ST_END: begin
                // last counter enters the accumulator this cycle
                state_next = S_ST_DIVGO;
            end
            S_ST_DIVGO: begin
                div_start  = 1'b1;
                div_din    = DIV_W'(st_sum);
                state_next = S_ST_DIV;
            end
            S_ST_DIV: begin
                if (div_done) begin
                    res_next          = '0;
                    res_next.status   = RES_OK;
                    res_next.last     = 1'b1;
                    res_next.stat_min = (st_min > OVF_W'(STAT_TOP)) ? '1 : STAT_W'(st_min);
                    res_next.stat_max = (st_max > OVF_W'(STAT_TOP)) ? '1 : STAT_W'(st_max);
                    res_next.stat_min_count = (int'(st_min_n) > SCNT_TOP) ? '1
                                                                        : SCNT_W'(st_min_n);
                    res_next.stat_max_count = (int'(st_max_n) > SCNT_TOP) ? '1
                                                                        : SCNT_W'(st_max_n);
                    res_next.stat_avg = (div_quo > DIV_W'(STAT_TOP)) ? '1 : STAT_W'(div_quo);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            nodes_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            nodes_reg <= nodes_next;
            rd_v_reg  <= rd_v_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_reg        <= b_next;
        key_reg      <= key_next;
        tail_reg     <= tail_next;
        node_reg     <= node_next;
        pos_reg      <= pos_next;
        st_idx_reg   <= st_idx_next;
        rd_first_reg <= rd_first_next;
        rd_used_reg  <= rd_used_next;
        res_reg      <= res_next;
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    // operations are serialised, so a read never meets a write to the same entry
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bkt_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            bm_rdata_reg <= bkt_mem[bm_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (nm_key_we) begin
            node_mem[nm_waddr].key <= nm_wdata.key;
        end
        if (nm_link_we) begin
            node_mem[nm_waddr].link <= nm_wdata.link;
        end
        if (nm_re) begin
            nm_rdata_reg <= node_mem[nm_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CHT_ASSERT_ALWAYS(a_pool_bound, nodes_reg <= POOL_LIMIT, "node count past pool size")
    `CHT_ASSERT_IMPLY(a_alloc_not_full, nm_key_we, !pool_full, "node taken from a full pool")
    `CHT_ASSERT_IMPLY(a_div_done_waited, div_done, div_wait, "divider result with nobody waiting")
    `CHT_ASSERT_IMPLY(a_out_no_overwrite, out_load, out_free, "result register overwritten")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// self-checking bench for chained_hash_table_with_overflow_stats_core
// a behavioural mirror of the chains and counters predicts every result transaction
// depends on cht_pkg and the core rtl only
module tb;
    import cht_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NODE_W   = $clog2(POOL_SIZE_DEF);
    localparam int LIST_MAX = 64;

    // mirror of bucket chains, node pool and overflow counters
    class hash_chain_mirror;
        bit                  occupied  [NUM_BUCKETS_DEF];
        logic [NODE_W-1:0]   head_node [NUM_BUCKETS_DEF];
        logic [NODE_W-1:0]   tail_node [NUM_BUCKETS_DEF];
        logic [NODE_W-1:0]   link      [POOL_SIZE_DEF];
        logic [KEY_BITS-1:0] node_key  [POOL_SIZE_DEF];
        logic [OVF_W-1:0]    overflows [NUM_BUCKETS_DEF];
        int                  nodes_taken;
        cht_out_t            due_results[$];
        int                  mismatches;

        function new();
            foreach (occupied[i]) begin
                occupied[i]  = 1'b0;
                head_node[i] = '0;
                tail_node[i] = '0;
                overflows[i] = '0;
            end
            foreach (link[i]) begin
                link[i]     = '0;
                node_key[i] = '0;
            end
            nodes_taken = 0;
            mismatches  = 0;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        // work out the result transactions of one accepted operation
        function void absorb_op(cht_in_t op_in);
            cht_out_t          r;
            int                b;
            int                k;
            int unsigned       lo, hi, lo_n, hi_n, total;
            logic [NODE_W-1:0] node;
            bit                done;
            r = '0;
            r.last = 1'b1;
            case (op_in.op)
                OP_INSERT: begin
                    b = op_in.key % NUM_BUCKETS_DEF;
                    r.bucket_out = BKT_OUT_W'(b);
                    if (nodes_taken >= POOL_SIZE_DEF) begin
                        r.status = RES_POOL_FULL;
                    end else begin
                        node = NODE_W'(nodes_taken);
                        nodes_taken++;
                        node_key[node] = op_in.key;
                        link[node] = '0;
                        if (occupied[b]) begin
                            link[tail_node[b]] = node;
                            if (overflows[b] < OVF_MAX)
                                overflows[b]++;
                            r.position = POS_W'(overflows[b]);
                        end else begin
                            occupied[b]  = 1'b1;
                            head_node[b] = node;
                        end
                        tail_node[b] = node;
                        r.status = RES_OK;
                    end
                    due_results.push_back(r);
                end
                OP_STATS: begin
                    lo = overflows[0];
                    hi = lo;
                    lo_n = 1;
                    hi_n = 1;
                    total = lo;
                    for (int i = 1; i < NUM_BUCKETS_DEF; i++) begin
                        total += overflows[i];
                        if (overflows[i] > hi) begin
                            hi = overflows[i];
                            hi_n = 1;
                        end else if (overflows[i] == hi) begin
                            hi_n++;
                        end
                        if (overflows[i] < lo) begin
                            lo = overflows[i];
                            lo_n = 1;
                        end else if (overflows[i] == lo) begin
                            lo_n++;
                        end
                    end
                    total = total / NUM_BUCKETS_DEF;
                    r.status         = RES_OK;
                    r.stat_min       = STAT_W'((lo > STAT_TOP) ? STAT_TOP : lo);
                    r.stat_min_count = SCNT_W'((lo_n > SCNT_TOP) ? SCNT_TOP : lo_n);
                    r.stat_max       = STAT_W'((hi > STAT_TOP) ? STAT_TOP : hi);
                    r.stat_max_count = SCNT_W'((hi_n > SCNT_TOP) ? SCNT_TOP : hi_n);
                    r.stat_avg       = STAT_W'((total > STAT_TOP) ? STAT_TOP : total);
                    due_results.push_back(r);
                end
                OP_LIST: begin
                    b = op_in.bucket;
                    r.bucket_out = op_in.bucket;
                    if (b >= NUM_BUCKETS_DEF) begin
                        r.status = RES_BAD_BUCKET;
                        due_results.push_back(r);
                    end else if (!occupied[b]) begin
                        r.status = RES_EMPTY;
                        due_results.push_back(r);
                    end else begin
                        node = head_node[b];
                        k = 0;
                        done = 1'b0;
                        while (!done) begin
                            done = (node == tail_node[b]) || (k + 1 >= LIST_MAX);
                            r.status   = RES_OK;
                            r.key_out  = node_key[node];
                            r.position = POS_W'(k);
                            r.last     = done;
                            due_results.push_back(r);
                            k++;
                            node = link[node];
                        end
                    end
                end
                default: begin
                    // unused op code gives no result
                end
            endcase
        endfunction

        task compare_result(cht_out_t got);
            cht_out_t want;
            string    bad;
            if (due_results.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = due_results.pop_front();
            bad = "";
            if (got.status !== want.status)                 bad = {bad, " status"};
            if (got.bucket_out !== want.bucket_out)         bad = {bad, " bucket_out"};
            if (got.key_out !== want.key_out)               bad = {bad, " key_out"};
            if (got.position !== want.position)             bad = {bad, " position"};
            if (got.stat_min !== want.stat_min)             bad = {bad, " stat_min"};
            if (got.stat_min_count !== want.stat_min_count) bad = {bad, " stat_min_count"};
            if (got.stat_max !== want.stat_max)             bad = {bad, " stat_max"};
            if (got.stat_max_count !== want.stat_max_count) bad = {bad, " stat_max_count"};
            if (got.stat_avg !== want.stat_avg)             bad = {bad, " stat_avg"};
            if (got.last !== want.last)                     bad = {bad, " last"};
            if (bad != "")
                report($sformatf("fields%s differ: got %h want %h", bad, got, want));
        endtask
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cht_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cht_out_t m_data;

    bit steady = 1'b0;
    hash_chain_mirror mirror = new();

    chained_hash_table_with_overflow_stats_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.compare_result(m_data);
    end

    function automatic cht_in_t make_op(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                                        logic [BKT_IN_W-1:0] bucket);
        cht_in_t it;
        it.op     = op;
        it.key    = key;
        it.bucket = bucket;
        return it;
    endfunction

    // inserts lean towards bucket 3 so one chain grows long
    function automatic cht_in_t random_op();
        cht_in_t it;
        int      pick;
        it.key    = KEY_BITS'($urandom);
        it.bucket = BKT_IN_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.op = OP_INSERT;
            if ($urandom_range(0, 99) < 40)
                it.key = KEY_BITS'(7 * $urandom_range(0, 9361) + 3);
        end else if (pick < 60) begin
            it.op = OP_STATS;
        end else if (pick < 95) begin
            it.op = OP_LIST;
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // entered and left just after a falling edge
    task automatic send_op(input cht_in_t item);
        while (!steady && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.absorb_op(item);
        @(negedge aclk);
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (mirror.due_results.size() != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table, invalid bucket, unused op
        send_op(make_op(OP_STATS, '0, '0));
        send_op(make_op(OP_LIST, '0, 3'd0));
        send_op(make_op(OP_LIST, '1, 3'd7));
        send_op(make_op(OP_UNUSED, 16'h1234, 3'd2));
        // key extremes and chain growth in bucket 0
        send_op(make_op(OP_INSERT, 16'h0000, '0));
        send_op(make_op(OP_INSERT, 16'hffff, '1));
        send_op(make_op(OP_INSERT, 16'd7, '0));
        send_op(make_op(OP_INSERT, 16'd14, '0));
        send_op(make_op(OP_INSERT, 16'd65534, '0));
        send_op(make_op(OP_INSERT, 16'd6, '0));
        send_op(make_op(OP_INSERT, 16'h5555, '0));
        send_op(make_op(OP_INSERT, 16'haaaa, '0));
        send_op(make_op(OP_LIST, '0, 3'd0));
        send_op(make_op(OP_LIST, '0, 3'd1));
        send_op(make_op(OP_LIST, '0, 3'd6));
        send_op(make_op(OP_LIST, '0, 3'd5));
        send_op(make_op(OP_STATS, 16'hffff, 3'd7));
        send_op(make_op(OP_UNUSED, 16'hffff, 3'd7));
        wait_quiet();

        for (int n = 0; n < 192; n++) begin
            steady = (n >= 90 && n < 140);
            if (n % 50 == 49)
                wait_quiet();
            send_op(random_op());
        end
        wait_quiet();
        repeat (100) @(posedge aclk);

        if (mirror.mismatches == 0 && mirror.due_results.size() == 0)
            $display("PASS chained_hash_table_with_overflow_stats_core");
        else
            $display("FAIL chained_hash_table_with_overflow_stats_core");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL chained_hash_table_with_overflow_stats_core");
        $finish;
    end
endmodule
